[design/pfcs_pkg.sv]
// Shared types, codes and constants of the parallel flash command sequencer.
package pfcs_pkg;

  // Flash address layout.
  localparam int unsigned SECTOR_SHIFT = 10;
  localparam int unsigned BUS_WIDTH    = 16;
  localparam logic [15:0] BUS_MASK     = (BUS_WIDTH >= 16) ? 16'hFFFF
                                         : 16'((32'd1 << BUS_WIDTH) - 32'd1);

  // JEDEC unlock addresses and data words.
  localparam logic [15:0] ADDR_A      = 16'h5555;
  localparam logic [15:0] ADDR_B      = 16'h2AAA;
  localparam logic [15:0] DATA_A      = 16'hAAAA;
  localparam logic [15:0] DATA_B      = 16'h5555;
  localparam logic [15:0] CMD_ERASE   = 16'h8080;
  localparam logic [15:0] CMD_CHIP    = 16'h1010;
  localparam logic [15:0] CMD_SECTOR  = 16'h3030;
  localparam logic [15:0] CMD_PROGRAM = 16'hA0A0;

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_PROGRAM_WAIT = 2'd1;
  localparam logic [1:0] REG_SECTOR_WAIT  = 2'd2;
  localparam logic [1:0] REG_CHIP_WAIT    = 2'd3;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd2000;
  localparam logic [7:0]  PROGRAM_WAIT_RST = 8'd21;
  localparam logic [19:0] SECTOR_WAIT_RST  = 20'd26000;
  localparam logic [19:0] CHIP_WAIT_RST    = 20'd101000;

  // Command codes; codes above OP_TICK are unknown.
  typedef enum logic [3:0] {
    OP_STATUS  = 4'd0,
    OP_BREAK   = 4'd1,
    OP_CHIP    = 4'd2,
    OP_SECTOR  = 4'd3,
    OP_PROGRAM = 4'd4,
    OP_READ    = 4'd5,
    OP_VERIFY  = 4'd6,
    OP_HOLD    = 4'd7,
    OP_RELEASE = 4'd8,
    OP_TICK    = 4'd9
  } op_e;

  // Bus cycle kinds of a result.
  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_READ   = 3'd1,
    KIND_WAIT   = 3'd2,
    KIND_BREAK  = 3'd3,
    KIND_STATUS = 3'd4
  } kind_e;

  // Status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_POWER   = 3'd1,
    ST_BAD_SECTOR = 3'd2,
    ST_VERIFY     = 3'd3,
    ST_UNKNOWN    = 3'd4
  } status_e;

  // Result sequence that the back end plays out for one command.
  typedef enum logic [2:0] {
    SEQ_STATUS,
    SEQ_BREAK,
    SEQ_CHIP,
    SEQ_SECTOR,
    SEQ_PROGRAM,
    SEQ_READ
  } seq_e;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    seq_e        seq;
    logic [15:0] addr;
    logic [15:0] data;
    logic [19:0] wait_us;
    logic [7:0]  bp_en;
    status_e     status;
    logic        hold;
  } desc_t;

endpackage

[design/pfcs_front.sv]
// Front end: accepts commands, holds configuration and state, classifies commands.
module pfcs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [19:0]         cfg_data_i,
  input  logic                accept_i,
  input  logic [3:0]          op_i,
  input  logic                vdd_i,
  input  logic [5:0]          sector_i,
  input  logic [9:0]          offset_i,
  input  logic [15:0]         wdata_i,
  input  logic [15:0]         rdata_i,
  input  logic [15:0]         bp_addr_i,
  input  logic [7:0]          bp_en_i,
  output pfcs_pkg::desc_t     desc_o
);
  import pfcs_pkg::*;

  logic [15:0] timeout_q;
  logic [7:0]  prog_wait_q;
  logic [19:0] sector_wait_q;
  logic [19:0] chip_wait_q;
  logic        hold_q, hold_d;
  logic [15:0] idle_q, idle_d;
  logic [31:0] saddr_wide;
  logic [31:0] waddr_wide;
  desc_t       desc;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= IDLE_TIMEOUT_RST;
      prog_wait_q   <= PROGRAM_WAIT_RST;
      sector_wait_q <= SECTOR_WAIT_RST;
      chip_wait_q   <= CHIP_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IDLE_TIMEOUT: timeout_q     <= cfg_data_i[15:0];
        REG_PROGRAM_WAIT: prog_wait_q   <= cfg_data_i[7:0];
        REG_SECTOR_WAIT:  sector_wait_q <= cfg_data_i;
        REG_CHIP_WAIT:    chip_wait_q   <= cfg_data_i;
        default:          timeout_q     <= timeout_q;
      endcase
    end
  end

  // Flash addresses of the command.
  assign saddr_wide = 32'(sector_i) << SECTOR_SHIFT;
  assign waddr_wide = saddr_wide | 32'(offset_i);

  // Classification and next hold and idle state.
  always_comb begin
    hold_d       = hold_q;
    idle_d       = 16'd0;
    desc.seq     = SEQ_STATUS;
    desc.addr    = 16'd0;
    desc.data    = 16'd0;
    desc.wait_us = 20'd0;
    desc.bp_en   = 8'd0;
    desc.status  = ST_OK;
    if (op_i == OP_TICK) begin
      // A tick counts idle time and releases the hold after the timeout.
      if (idle_q < timeout_q) begin
        idle_d = idle_q + 16'd1;
      end else begin
        idle_d = idle_q;
        hold_d = 1'b0;
      end
    end else if (op_i > OP_TICK) begin
      desc.status = ST_UNKNOWN;
    end else if (!vdd_i) begin
      desc.status = ST_NO_POWER;
    end else begin
      unique case (op_i)
        OP_BREAK: begin
          desc.seq   = SEQ_BREAK;
          desc.addr  = bp_addr_i;
          desc.bp_en = bp_en_i;
        end
        OP_CHIP: begin
          desc.seq     = SEQ_CHIP;
          desc.wait_us = chip_wait_q;
        end
        OP_SECTOR: begin
          if (sector_i[1:0] != 2'b00) begin
            desc.status = ST_BAD_SECTOR;
          end else begin
            desc.seq     = SEQ_SECTOR;
            desc.addr    = saddr_wide[15:0];
            desc.wait_us = sector_wait_q;
          end
        end
        OP_PROGRAM: begin
          desc.seq     = SEQ_PROGRAM;
          desc.addr    = waddr_wide[15:0];
          desc.data    = wdata_i;
          desc.wait_us = 20'(prog_wait_q);
        end
        OP_READ: begin
          desc.seq  = SEQ_READ;
          desc.addr = waddr_wide[15:0];
        end
        OP_VERIFY: begin
          desc.seq  = SEQ_READ;
          desc.addr = waddr_wide[15:0];
          if (wdata_i != rdata_i) desc.status = ST_VERIFY;
        end
        OP_HOLD:    hold_d = 1'b1;
        OP_RELEASE: hold_d = 1'b0;
        default:    hold_d = hold_q;
      endcase
    end
    // Any error drops the reset hold.
    if (desc.status != ST_OK) hold_d = 1'b0;
    desc.hold = hold_d;
  end

  assign desc_o = desc;

  // Hold flag and idle counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      idle_q <= 16'd0;
    end else if (accept_i) begin
      hold_q <= hold_d;
      idle_q <= idle_d;
    end
  end

endmodule

[design/pfcs_queue.sv]
// Two-entry queue of classified commands between the front and back ends.
module pfcs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pfcs_pkg::desc_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output pfcs_pkg::desc_t pop_data_o
);
  import pfcs_pkg::*;

  desc_t      mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  assign full_o     = count_q == 2'd2;
  assign valid_o    = count_q != 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

endmodule

[design/pfcs_back.sv]
// Back end: plays out the bus cycles of each command into an output register.
module pfcs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            desc_valid_i,
  input  pfcs_pkg::desc_t desc_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      kind_o,
  output logic [15:0]     addr_o,
  output logic [15:0]     data_o,
  output logic [19:0]     wait_o,
  output logic [7:0]      bp_en_o,
  output logic [2:0]      status_o,
  output logic            hold_o,
  output logic            last_o
);
  import pfcs_pkg::*;

  logic [2:0]  step_q;
  logic        valid_q;
  logic        load;
  kind_e       kind;
  logic [15:0] addr;
  logic [15:0] data;
  logic [19:0] wait_us;
  logic [7:0]  bp_en;
  logic        is_last;
  kind_e       kind_q;
  logic [15:0] addr_q;
  logic [15:0] data_q;
  logic [19:0] wait_q;
  logic [7:0]  bp_en_q;
  status_e     status_q;
  logic        hold_q;
  logic        last_q;

  // Result of the current step of the current command.
  always_comb begin
    kind    = KIND_WRITE;
    addr    = 16'd0;
    data    = 16'd0;
    wait_us = 20'd0;
    bp_en   = 8'd0;
    is_last = 1'b0;
    unique case (desc_i.seq)
      SEQ_STATUS: begin
        kind    = KIND_STATUS;
        is_last = 1'b1;
      end
      SEQ_BREAK: begin
        kind    = KIND_BREAK;
        addr    = desc_i.addr;
        bp_en   = desc_i.bp_en;
        is_last = 1'b1;
      end
      SEQ_READ: begin
        kind    = KIND_READ;
        addr    = desc_i.addr;
        is_last = 1'b1;
      end
      SEQ_CHIP, SEQ_SECTOR: begin
        // Erase unlock, erase command, unlock again, the erase target, then the erase wait.
        case (step_q)
          3'd0: begin addr = ADDR_A; data = DATA_A;    end
          3'd1: begin addr = ADDR_B; data = DATA_B;    end
          3'd2: begin addr = ADDR_A; data = CMD_ERASE; end
          3'd3: begin addr = ADDR_A; data = DATA_A;    end
          3'd4: begin addr = ADDR_B; data = DATA_B;    end
          3'd5: begin
            if (desc_i.seq == SEQ_CHIP) begin
              addr = ADDR_A;
              data = CMD_CHIP;
            end else begin
              addr = desc_i.addr;
              data = CMD_SECTOR;
            end
          end
          default: begin
            kind    = KIND_WAIT;
            wait_us = desc_i.wait_us;
            is_last = 1'b1;
          end
        endcase
      end
      SEQ_PROGRAM: begin
        // Unlock, program command, the data word, then the program wait.
        case (step_q)
          3'd0: begin addr = ADDR_A;      data = DATA_A;      end
          3'd1: begin addr = ADDR_B;      data = DATA_B;      end
          3'd2: begin addr = ADDR_A;      data = CMD_PROGRAM; end
          3'd3: begin addr = desc_i.addr; data = desc_i.data; end
          default: begin
            kind    = KIND_WAIT;
            wait_us = desc_i.wait_us;
            is_last = 1'b1;
          end
        endcase
      end
      default: begin
        kind    = KIND_STATUS;
        is_last = 1'b1;
      end
    endcase
  end

  // The output register takes a new result when empty or being drained.
  assign load  = desc_valid_i && (!valid_q || out_ready_i);
  assign pop_o = load && is_last;

  // Step counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q <= is_last ? 3'd0 : step_q + 3'd1;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind;
      addr_q   <= addr & BUS_MASK;
      data_q   <= data & BUS_MASK;
      wait_q   <= wait_us;
      bp_en_q  <= bp_en;
      status_q <= desc_i.status;
      hold_q   <= desc_i.hold;
      last_q   <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign addr_o      = addr_q;
  assign data_o      = data_q;
  assign wait_o      = wait_q;
  assign bp_en_o     = bp_en_q;
  assign status_o    = status_q;
  assign hold_o      = hold_q;
  assign last_o      = last_q;

endmodule

[design/parallel_flash_command_sequencer.sv]
// Top level of the parallel NOR flash command sequencer.
// Each accepted command produces one to seven result transfers: erase commands give
// six write pulses and a wait, program gives four write pulses and a wait, and all
// other commands and all errors give a single result whose last flag is set. The front
// end takes a command in every cycle while its two-entry queue has room; the back end
// sends one result per cycle while the receiver is ready, and the first result is
// offered once the command has passed through the queue and the output register.
// Configuration writes are taken at once and must be made while the block is idle;
// they affect the commands taken afterward.
module parallel_flash_command_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  // Command stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // vdd_detected[0], sector[6:1], word_offset[16:7], word_data[32:17],
  // read_data[48:33], breakpoint_address[64:49], breakpoint_enable_in[72:65], zeros
  input  logic [79:0] s_axis_tdata,
  // operation[3:0]
  input  logic [3:0]  s_axis_tuser,
  // Bus cycle stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bus_address[15:0], bus_data[31:16], wait_time_us[51:32],
  // breakpoint_enable[59:52], status[62:60], hold_active[63]
  output logic [63:0] m_axis_tdata,
  // cycle_kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import pfcs_pkg::*;

  logic        in_accept;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  desc_t       front_desc;
  desc_t       back_desc;
  logic [15:0] out_addr;
  logic [15:0] out_data;
  logic [19:0] out_wait;
  logic [7:0]  out_bp_en;
  logic [2:0]  out_status;
  logic        out_hold;

  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  pfcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (in_accept),
    .op_i       (s_axis_tuser),
    .vdd_i      (s_axis_tdata[0]),
    .sector_i   (s_axis_tdata[6:1]),
    .offset_i   (s_axis_tdata[16:7]),
    .wdata_i    (s_axis_tdata[32:17]),
    .rdata_i    (s_axis_tdata[48:33]),
    .bp_addr_i  (s_axis_tdata[64:49]),
    .bp_en_i    (s_axis_tdata[72:65]),
    .desc_o     (front_desc)
  );

  pfcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_desc),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_data_o  (back_desc)
  );

  pfcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (q_valid),
    .desc_i       (back_desc),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .kind_o       (m_axis_tuser),
    .addr_o       (out_addr),
    .data_o       (out_data),
    .wait_o       (out_wait),
    .bp_en_o      (out_bp_en),
    .status_o     (out_status),
    .hold_o       (out_hold),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {out_hold, out_status, out_bp_en, out_wait, out_data, out_addr};

`ifndef SYNTH
  // The queue is never written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |-> !q_full)
    else $error("command queue overflow");

  // The back end only retires a command that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("command retired from empty queue");

  // Status-only, breakpoint, read and wait results always close a command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_WRITE) |-> m_axis_tlast)
    else $error("non-write result without last flag");

  // A reported error always comes with the reset hold released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_status != ST_OK) |-> !out_hold)
    else $error("error reported while reset hold active");
`endif

endmodule

[dv/parallel_flash_command_sequencer_tb.sv]
// Self-checking testbench for the parallel flash command sequencer.
`timescale 1ns / 1ps

module parallel_flash_command_sequencer_tb;
  import pfcs_pkg::*;

  // Unknown command codes lie above the tick code.
  localparam logic [3:0] OP_UNKNOWN_LO = 4'd10;
  localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_GAP     = 6;
  localparam int HOLDOFF_LEN   = 400;
  localparam int PRINT_CAP     = 40;

  // One command as offered on the input stream.
  typedef struct {
    logic [3:0]  op;
    logic        vdd;
    logic [5:0]  sector;
    logic [9:0]  offset;
    logic [15:0] wdata;
    logic [15:0] rdata;
    logic [15:0] bp_addr;
    logic [7:0]  bp_en;
    bit          drain_first;
  } cmd_t;

  // One bus cycle as it should leave the block.
  typedef struct {
    kind_e       kind;
    logic [15:0] addr;
    logic [15:0] data;
    logic [19:0] wait_us;
    logic [7:0]  bp_en;
    status_e     status;
    logic        hold;
    logic        last;
  } bus_cycle_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [19:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;
  logic [3:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  parallel_flash_command_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Stimulus and scoreboard storage.
  cmd_t       cmd_q[$];
  cmd_t       offered_cmd;
  bus_cycle_t bus_cycles_due[$];

  // Predicted block state and register copies.
  logic        pred_hold       = 1'b0;
  logic [15:0] pred_idle_ticks = '0;
  logic [15:0] timeout_ticks   = IDLE_TIMEOUT_RST;
  logic [7:0]  program_wait    = PROGRAM_WAIT_RST;
  logic [19:0] sector_wait     = SECTOR_WAIT_RST;
  logic [19:0] chip_wait       = CHIP_WAIT_RST;

  int  tx_idle_pct    = 28;
  int  rx_idle_pct    = 88;
  logic rx_hold       = 1'b0;
  int  holdoff_at     = 32'h7fff_ffff;
  int  taken_cnt      = 0;
  int  cycles_seen    = 0;
  int  mismatches     = 0;
  int  hold_releases  = 0;
  int  error_statuses = 0;
  int  clk_cycles     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // Printing is capped so that a broken build cannot flood the log.
    if (mismatches < PRINT_CAP)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h (result %0d)",
               $time, what, got, want, cycles_seen);
    mismatches++;
  endtask

  function automatic bus_cycle_t bus_cycle(input kind_e kind, input logic [15:0] addr,
                                           input logic [15:0] data,
                                           input logic [19:0] wait_us,
                                           input logic [7:0] bp_en, input status_e st);
    bus_cycle_t b;
    b.kind    = kind;
    b.addr    = addr;
    b.data    = data;
    b.wait_us = wait_us;
    b.bp_en   = bp_en;
    b.status  = st;
    b.hold    = 1'b0;
    b.last    = 1'b0;
    return b;
  endfunction

  // Works out the bus cycles of one taken command and queues them.
  function automatic void predict_bus_cycles(input cmd_t c);
    bus_cycle_t  seq[$];
    logic [31:0] flash_addr;
    logic [15:0] waddr;
    logic [15:0] saddr;
    status_e     err;
    err        = ST_OK;
    flash_addr = ({26'd0, c.sector} << SECTOR_SHIFT);
    saddr      = flash_addr[15:0] & BUS_MASK;
    flash_addr = flash_addr | {22'd0, c.offset};
    waddr      = flash_addr[15:0] & BUS_MASK;

    if (c.op == OP_TICK) begin
      // A tick skips the power check and leaves the idle count running.
      if (pred_idle_ticks < timeout_ticks) begin
        pred_idle_ticks = pred_idle_ticks + 16'd1;
      end else begin
        if (pred_hold) hold_releases++;
        pred_hold = 1'b0;
      end
      seq.push_back(bus_cycle(KIND_STATUS, '0, '0, '0, '0, ST_OK));
    end else begin
      pred_idle_ticks = '0;
      if (c.op > OP_TICK) begin
        err = ST_UNKNOWN;
        seq.push_back(bus_cycle(KIND_STATUS, '0, '0, '0, '0, err));
      end else if (!c.vdd) begin
        err = ST_NO_POWER;
        seq.push_back(bus_cycle(KIND_STATUS, '0, '0, '0, '0, err));
      end else begin
        case (c.op)
          OP_BREAK: begin
            seq.push_back(bus_cycle(KIND_BREAK, c.bp_addr, '0, '0, c.bp_en, ST_OK));
          end
          OP_CHIP, OP_SECTOR: begin
            if (c.op == OP_SECTOR && c.sector[1:0] != 2'b00) begin
              err = ST_BAD_SECTOR;
              seq.push_back(bus_cycle(KIND_STATUS, '0, '0, '0, '0, err));
            end else begin
              // Two unlock pairs around the erase setup word.
              seq.push_back(bus_cycle(KIND_WRITE, ADDR_A, DATA_A, '0, '0, ST_OK));
              seq.push_back(bus_cycle(KIND_WRITE, ADDR_B, DATA_B, '0, '0, ST_OK));
              seq.push_back(bus_cycle(KIND_WRITE, ADDR_A, CMD_ERASE, '0, '0, ST_OK));
              seq.push_back(bus_cycle(KIND_WRITE, ADDR_A, DATA_A, '0, '0, ST_OK));
              seq.push_back(bus_cycle(KIND_WRITE, ADDR_B, DATA_B, '0, '0, ST_OK));
              if (c.op == OP_CHIP) begin
                seq.push_back(bus_cycle(KIND_WRITE, ADDR_A, CMD_CHIP, '0, '0, ST_OK));
                seq.push_back(bus_cycle(KIND_WAIT, '0, '0, chip_wait, '0, ST_OK));
              end else begin
                seq.push_back(bus_cycle(KIND_WRITE, saddr, CMD_SECTOR, '0, '0, ST_OK));
                seq.push_back(bus_cycle(KIND_WAIT, '0, '0, sector_wait, '0, ST_OK));
              end
            end
          end
          OP_PROGRAM: begin
            seq.push_back(bus_cycle(KIND_WRITE, ADDR_A, DATA_A, '0, '0, ST_OK));
            seq.push_back(bus_cycle(KIND_WRITE, ADDR_B, DATA_B, '0, '0, ST_OK));
            seq.push_back(bus_cycle(KIND_WRITE, ADDR_A, CMD_PROGRAM, '0, '0, ST_OK));
            seq.push_back(bus_cycle(KIND_WRITE, waddr, c.wdata, '0, '0, ST_OK));
            seq.push_back(bus_cycle(KIND_WAIT, '0, '0, {12'd0, program_wait}, '0, ST_OK));
          end
          OP_READ: begin
            seq.push_back(bus_cycle(KIND_READ, waddr, '0, '0, '0, ST_OK));
          end
          OP_VERIFY: begin
            if (c.wdata != c.rdata) err = ST_VERIFY;
            seq.push_back(bus_cycle(KIND_READ, waddr, '0, '0, '0, err));
          end
          OP_HOLD: begin
            pred_hold = 1'b1;
            seq.push_back(bus_cycle(KIND_STATUS, '0, '0, '0, '0, ST_OK));
          end
          OP_RELEASE: begin
            pred_hold = 1'b0;
            seq.push_back(bus_cycle(KIND_STATUS, '0, '0, '0, '0, ST_OK));
          end
          default: begin
            seq.push_back(bus_cycle(KIND_STATUS, '0, '0, '0, '0, ST_OK));
          end
        endcase
      end
      // Any error drops the target reset hold.
      if (err != ST_OK) begin
        pred_hold = 1'b0;
        error_statuses++;
      end
    end

    foreach (seq[i]) begin
      seq[i].hold = pred_hold;
      seq[i].last = (i == seq.size() - 1);
      bus_cycles_due.push_back(seq[i]);
    end
  endfunction

  function automatic cmd_t mk_cmd(input logic [3:0] op, input logic vdd,
                                  input logic [5:0] sector, input logic [9:0] offset,
                                  input logic [15:0] wdata, input logic [15:0] rdata,
                                  input logic [15:0] bp_addr, input logic [7:0] bp_en);
    cmd_t c;
    c.op          = op;
    c.vdd         = vdd;
    c.sector      = sector;
    c.offset      = offset;
    c.wdata       = wdata;
    c.rdata       = rdata;
    c.bp_addr     = bp_addr;
    c.bp_en       = bp_en;
    c.drain_first = 1'b0;
    return c;
  endfunction

  // Random command content, biased toward the paths that do real work.
  function automatic cmd_t rand_cmd(input logic [3:0] op);
    cmd_t c;
    c = mk_cmd(op, $urandom_range(9) != 0, 6'($urandom_range(63)),
               10'($urandom_range(1023)), 16'($urandom), 16'($urandom),
               16'($urandom), 8'($urandom));
    if (op == OP_SECTOR && $urandom_range(3) != 0) c.sector[1:0] = 2'b00;
    if (op == OP_VERIFY && $urandom_range(1) != 0) c.rdata = c.wdata;
    return c;
  endfunction

  // Queues random commands; one command in the middle waits for a full drain.
  task automatic queue_random(input int n);
    cmd_t burst[$];
    int   made;
    int   k;
    bit   paused;
    logic [3:0] op;
    made   = 0;
    paused = 0;
    while (made < n) begin
      burst.delete();
      if ($urandom_range(99) < 12) begin
        // Hold followed by a random run of ticks that can cross a small idle timeout.
        burst.push_back(rand_cmd(OP_HOLD));
        burst[0].vdd = 1'b1;
        k = (timeout_ticks < 6) ? $urandom_range(timeout_ticks + 2) : $urandom_range(4);
        repeat (k) burst.push_back(rand_cmd(OP_TICK));
      end else begin
        if ($urandom_range(99) < 7) op = 4'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
        else op = 4'($urandom_range(OP_TICK, OP_STATUS));
        burst.push_back(rand_cmd(op));
      end
      foreach (burst[i]) begin
        if (!paused && made >= n / 2) begin
          burst[i].drain_first = 1'b1;
          paused = 1;
        end
        cmd_q.push_back(burst[i]);
        made++;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_IDLE_TIMEOUT: timeout_ticks = val[15:0];
      REG_PROGRAM_WAIT: program_wait  = val[7:0];
      REG_SECTOR_WAIT:  sector_wait   = val;
      REG_CHIP_WAIT:    chip_wait     = val;
      default: ;
    endcase
  endtask

  // Blocks until every queued command is taken and all its cycles have come.
  task automatic wait_drained();
    while (cmd_q.size() != 0 || s_axis_tvalid || bus_cycles_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // Command driver: offers queued commands with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_bus_cycles(offered_cmd);
        taken_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
            !(cmd_q[0].drain_first && bus_cycles_due.size() != 0)) begin
          offered_cmd = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, offered_cmd.bp_en, offered_cmd.bp_addr,
                            offered_cmd.rdata, offered_cmd.wdata, offered_cmd.offset,
                            offered_cmd.sector, offered_cmd.vdd};
          s_axis_tuser  <= offered_cmd.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Bus cycle monitor: compares each transfer with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : bus_monitor
    bus_cycle_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        cycles_seen++;
        if (bus_cycles_due.size() == 0) begin
          report_mismatch("bus cycle with none expected", {29'd0, m_axis_tuser}, '0);
        end else begin
          want = bus_cycles_due.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch("cycle kind", {29'd0, m_axis_tuser}, {29'd0, want.kind});
          if (m_axis_tdata[15:0] !== want.addr)
            report_mismatch("bus address", {16'd0, m_axis_tdata[15:0]}, {16'd0, want.addr});
          if (m_axis_tdata[31:16] !== want.data)
            report_mismatch("bus data", {16'd0, m_axis_tdata[31:16]}, {16'd0, want.data});
          if (m_axis_tdata[51:32] !== want.wait_us)
            report_mismatch("wait time", {12'd0, m_axis_tdata[51:32]}, {12'd0, want.wait_us});
          if (m_axis_tdata[59:52] !== want.bp_en)
            report_mismatch("breakpoint enable", {24'd0, m_axis_tdata[59:52]},
                            {24'd0, want.bp_en});
          if (m_axis_tdata[62:60] !== want.status)
            report_mismatch("status", {29'd0, m_axis_tdata[62:60]}, {29'd0, want.status});
          if (m_axis_tdata[63] !== want.hold)
            report_mismatch("hold flag", {31'd0, m_axis_tdata[63]}, {31'd0, want.hold});
          if (m_axis_tlast !== want.last)
            report_mismatch("last flag", {31'd0, m_axis_tlast}, {31'd0, want.last});
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long receiver hold-off so the block fills up and stalls its input.
  initial begin : rx_holdoff
    wait (taken_cnt >= holdoff_at);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLDOFF_LEN) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    clk_cycles++;
    if (clk_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bus cycles outstanding",
               clk_cycles, bus_cycles_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed commands under the reset register values.
    cmd_q.push_back(mk_cmd(OP_STATUS, 1'b1, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_STATUS, 1'b0, '1, '1, '1, '1, '1, '1));
    cmd_q.push_back(mk_cmd(OP_BREAK, 1'b1, '0, '0, '0, '0, 16'hFFFF, 8'hFF));
    cmd_q.push_back(mk_cmd(OP_BREAK, 1'b1, '1, '1, '1, '1, 16'h0000, 8'h00));
    cmd_q.push_back(mk_cmd(OP_CHIP, 1'b1, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_SECTOR, 1'b1, 6'd0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_SECTOR, 1'b1, 6'd60, '1, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_SECTOR, 1'b1, 6'd63, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_SECTOR, 1'b1, 6'd1, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_PROGRAM, 1'b1, 6'd63, 10'd1023, 16'hFFFF, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_PROGRAM, 1'b1, 6'd0, 10'd0, 16'h0000, '1, '1, '1));
    cmd_q.push_back(mk_cmd(OP_READ, 1'b1, 6'd63, 10'd1023, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_VERIFY, 1'b1, 6'd21, 10'd341, 16'hA5A5, 16'hA5A5, '0, '0));
    cmd_q.push_back(mk_cmd(OP_HOLD, 1'b1, '0, '0, '0, '0, '0, '0));
    // Verify mismatch, then loss of power, then unknown codes, each under a hold.
    cmd_q.push_back(mk_cmd(OP_VERIFY, 1'b1, 6'd42, 10'd682, 16'h5A5A, 16'h5A5B, '0, '0));
    cmd_q.push_back(mk_cmd(OP_HOLD, 1'b1, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_CHIP, 1'b0, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_HOLD, 1'b1, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_UNKNOWN_LO, 1'b1, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_HOLD, 1'b1, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_UNKNOWN_HI, 1'b0, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_HOLD, 1'b1, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_TICK, 1'b0, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_RELEASE, 1'b1, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_READ, 1'b0, 6'd5, 10'd5, '0, '0, '0, '0));
    wait_drained();

    // Zero timeout: a tick releases the hold at once; program and chip waits at their tops, sector wait at zero.
    write_reg(REG_IDLE_TIMEOUT, 20'd0);
    write_reg(REG_PROGRAM_WAIT, 20'hFFFFF);
    write_reg(REG_SECTOR_WAIT, 20'd0);
    write_reg(REG_CHIP_WAIT, 20'hFFFFF);
    cmd_q.push_back(mk_cmd(OP_HOLD, 1'b1, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_TICK, 1'b1, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk_cmd(OP_TICK, 1'b1, '0, '0, '0, '0, '0, '0));
    queue_random(150);
    wait_drained();

    // Slow sender, fast receiver; short timeout and the other wait extremes.
    tx_idle_pct = 88;
    rx_idle_pct = 28;
    write_reg(REG_IDLE_TIMEOUT, 20'd3);
    write_reg(REG_PROGRAM_WAIT, 20'hABC00);
    write_reg(REG_SECTOR_WAIT, 20'hFFFFF);
    write_reg(REG_CHIP_WAIT, 20'd0);
    queue_random(150);
    wait_drained();

    // Full rate on both sides, largest timeout, with one long receiver hold-off.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_IDLE_TIMEOUT, 20'hFFFFF);
    write_reg(REG_PROGRAM_WAIT, 20'($urandom_range(255)));
    write_reg(REG_SECTOR_WAIT, 20'($urandom));
    write_reg(REG_CHIP_WAIT, 20'($urandom));
    holdoff_at = taken_cnt + 30;
    queue_random(150);
    wait_drained();

    $display("Ran %0d commands over three pacing patterns and four register settings; %0d bus cycles checked.",
             taken_cnt, cycles_seen);
    $display("Saw %0d error statuses and %0d holds released by the idle timeout.",
             error_statuses, hold_releases);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
design/pfcs_pkg.sv
design/pfcs_front.sv
design/pfcs_queue.sv
design/pfcs_back.sv
design/parallel_flash_command_sequencer.sv
dv/parallel_flash_command_sequencer_tb.sv
